// ===== hdl/move_multiple_register_sequencer_defines.svh =====
// Assertion macros for the move-multiple sequencer.
`ifndef MOVE_MULTIPLE_REGISTER_SEQUENCER_DEFINES_SVH
`define MOVE_MULTIPLE_REGISTER_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that cons holds in the same cycle whenever ante holds.
`define MMRS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Checks that cons holds in the cycle after ante holds.
`define MMRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMRS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MMRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/mmrs_pkg.sv =====
// Types and constants shared by the move-multiple sequencer files.
package mmrs_pkg;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ILLEGAL = 2'd1,
      ST_UNIMPL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_PCINC,
      SEQ_SCAN
   } seq_state_type;

   localparam logic [2:0] MODE_ADDR_IND = 3'd2;
   localparam logic [2:0] MODE_POSTINC  = 3'd3;
   localparam logic [2:0] MODE_PREDEC   = 3'd4;
   localparam logic [2:0] MODE_DISP     = 3'd5;
   localparam logic [2:0] MODE_INDEX    = 3'd6;
   localparam logic [2:0] MODE_EXT      = 3'd7;

   // Extended-mode subcodes up to this one are real but not implemented.
   localparam logic [2:0] EXT_LAST_UNIMPL = 3'd3;

   localparam logic [31:0] LONG_STEP_UP   = 32'd4;
   localparam logic [31:0] LONG_STEP_DOWN = 32'hFFFF_FFFC;
   localparam logic [31:0] EXT_WORD_SIZE  = 32'd2;

endpackage

// ===== hdl/mmrs_req_if.sv =====
// Input channel carrying one move-multiple instruction per transfer.
interface mmrs_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  ea_mode;
   logic [2:0]  reg_field;
   logic [15:0] reg_list;
   logic [31:0] base_address;
   logic [31:0] pc_in;

   modport source (output valid, kind, ea_mode, reg_field, reg_list, base_address, pc_in,
                   input ready);
   modport sink (input valid, kind, ea_mode, reg_field, reg_list, base_address, pc_in,
                 output ready);
endinterface

// ===== hdl/mmrs_rsp_if.sv =====
// Result channel carrying one memory access or status item per transfer.
interface mmrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        access_valid;
   logic        is_store;
   logic [31:0] access_address;
   logic [3:0]  reg_index;
   logic [31:0] new_base;
   logic [31:0] next_pc;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, access_valid, is_store, access_address, reg_index,
                   new_base, next_pc, status, last, input ready);
   modport sink (input valid, access_valid, is_store, access_address, reg_index,
                 new_base, next_pc, status, last, output ready);
endinterface

// ===== hdl/move_multiple_register_sequencer.sv =====
// Long-word move-multiple sequencer: expands a register mask into memory accesses.
//
// The req channel takes one instruction: direction, addressing mode, register
// field, 16-bit register mask, base register value and pc. The rsp channel
// returns one transfer per set mask bit, each with its byte address and
// register index; the final transfer is marked last and carries the updated
// base and pc+2. A bad direction or mode, or an empty mask, gives a single status transfer.
//
// Sequence: after a request transfer, the PCINC state computes pc+2 on the shared
// 32-bit adder, then the mask is scanned one bit per cycle, starting with
// bit 0, and the same adder steps the address. The scan stops at the highest
// set bit, whose result is marked last; a new request is taken only once the
// sequencer is back in idle.
// req.ready is high only while no instruction is in progress.
// The result register holds one item; when the receiver stalls, the scan
// waits on set bits until the register frees up, and no item is dropped.
// A synchronous reset returns the sequencer to idle and empties the result
// register.
`include "move_multiple_register_sequencer_defines.svh"

module move_multiple_register_sequencer (
   input  logic           clock,
   input  logic           reset,
   mmrs_req_if.sink       req_ch,
   mmrs_rsp_if.source     rsp_ch
);

   mmrs_pkg::seq_state_type state_ff, state_in;
   mmrs_pkg::status_type    status_ff, status_in, decode_status;
   logic        store_ff, store_in;
   logic [15:0] mask_ff, mask_in;
   logic [3:0]  bit_ff, bit_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] pc_ff, pc_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_access_ff, out_access_in;
   logic        out_store_ff, out_store_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic [3:0]  out_reg_ff, out_reg_in;
   logic [31:0] out_base_ff, out_base_in;
   logic [31:0] out_pc_ff, out_pc_in;
   mmrs_pkg::status_type out_status_ff, out_status_in;
   logic        out_last_ff, out_last_in;

   logic        accept;
   logic        slot_free;
   logic        emit;
   logic        emit_last;
   logic [31:0] add_a, add_b, add_sum;

   assign accept    = req_ch.valid && req_ch.ready;
   assign slot_free = !out_valid_ff || rsp_ch.ready;

   // Mode and direction check for the incoming instruction.
   always_comb begin
      priority if (req_ch.ea_mode == mmrs_pkg::MODE_PREDEC) begin
         decode_status = !req_ch.kind ? mmrs_pkg::ST_OK : mmrs_pkg::ST_ILLEGAL;
      end else if (req_ch.ea_mode == mmrs_pkg::MODE_POSTINC) begin
         decode_status = req_ch.kind ? mmrs_pkg::ST_OK : mmrs_pkg::ST_ILLEGAL;
      end else if (req_ch.ea_mode == mmrs_pkg::MODE_ADDR_IND
                   || req_ch.ea_mode == mmrs_pkg::MODE_DISP
                   || req_ch.ea_mode == mmrs_pkg::MODE_INDEX) begin
         decode_status = mmrs_pkg::ST_UNIMPL;
      end else if (req_ch.ea_mode == mmrs_pkg::MODE_EXT) begin
         decode_status = (req_ch.reg_field <= mmrs_pkg::EXT_LAST_UNIMPL)
                         ? mmrs_pkg::ST_UNIMPL : mmrs_pkg::ST_ILLEGAL;
      end else begin
         decode_status = mmrs_pkg::ST_ILLEGAL;
      end
   end

   // The single shared adder: pc+2 in the first step, address steps after that.
   always_comb begin
      if (state_ff == mmrs_pkg::SEQ_PCINC) begin
         add_a = pc_ff;
         add_b = mmrs_pkg::EXT_WORD_SIZE;
      end else begin
         add_a = addr_ff;
         add_b = store_ff ? mmrs_pkg::LONG_STEP_DOWN : mmrs_pkg::LONG_STEP_UP;
      end
   end
   assign add_sum = add_a + add_b;

   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      store_in      = store_ff;
      mask_in       = mask_ff;
      bit_in        = bit_ff;
      addr_in       = addr_ff;
      pc_in         = pc_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_access_in = out_access_ff;
      out_store_in  = out_store_ff;
      out_addr_in   = out_addr_ff;
      out_reg_in    = out_reg_ff;
      out_base_in   = out_base_ff;
      out_pc_in     = out_pc_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      emit          = 1'b0;
      emit_last     = 1'b0;

      unique case (state_ff)
         mmrs_pkg::SEQ_IDLE: begin
            if (accept) begin
               status_in  = decode_status;
               store_in   = !req_ch.kind;
               mask_in    = req_ch.reg_list;
               bit_in     = '0;
               addr_in    = req_ch.base_address;
               pc_in      = req_ch.pc_in;
               state_in   = mmrs_pkg::SEQ_PCINC;
            end
         end
         mmrs_pkg::SEQ_PCINC: begin
            pc_in      = add_sum;
            state_in   = mmrs_pkg::SEQ_SCAN;
         end
         mmrs_pkg::SEQ_SCAN: begin
            if (status_ff != mmrs_pkg::ST_OK || mask_ff == '0) begin
               // Single closing item: an error, or an empty register list.
               if (slot_free) begin
                  emit          = 1'b1;
                  emit_last     = 1'b1;
                  out_access_in = 1'b0;
                  out_addr_in   = '0;
                  out_reg_in    = '0;
                  out_base_in   = (status_ff == mmrs_pkg::ST_OK) ? addr_ff : '0;
                  out_pc_in     = (status_ff == mmrs_pkg::ST_OK) ? pc_ff : '0;
               end
            end else if (mask_ff[0]) begin
               if (slot_free) begin
                  emit          = 1'b1;
                  emit_last     = (mask_ff[15:1] == '0);
                  out_access_in = 1'b1;
                  out_addr_in   = store_ff ? add_sum : addr_ff;
                  out_reg_in    = store_ff ? ~bit_ff : bit_ff;
                  out_base_in   = emit_last ? add_sum : '0;
                  out_pc_in     = emit_last ? pc_ff : '0;
                  addr_in       = add_sum;
                  mask_in       = mask_ff >> 1;
                  bit_in        = bit_ff + 4'd1;
               end
            end else begin
               mask_in = mask_ff >> 1;
               bit_in  = bit_ff + 4'd1;
            end
            if (emit) begin
               out_valid_in  = 1'b1;
               out_store_in  = store_ff;
               out_status_in = status_ff;
               out_last_in   = emit_last;
               if (emit_last) begin
                  state_in = mmrs_pkg::SEQ_IDLE;
               end
            end
         end
         default: begin
            state_in = mmrs_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmrs_pkg::SEQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      store_ff      <= store_in;
      mask_ff       <= mask_in;
      bit_ff        <= bit_in;
      addr_ff       <= addr_in;
      pc_ff         <= pc_in;
      out_access_ff <= out_access_in;
      out_store_ff  <= out_store_in;
      out_addr_ff   <= out_addr_in;
      out_reg_ff    <= out_reg_in;
      out_base_ff   <= out_base_in;
      out_pc_ff     <= out_pc_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign req_ch.ready          = (state_ff == mmrs_pkg::SEQ_IDLE);
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.access_valid   = out_access_ff;
   assign rsp_ch.is_store       = out_store_ff;
   assign rsp_ch.access_address = out_addr_ff;
   assign rsp_ch.reg_index      = out_reg_ff;
   assign rsp_ch.new_base       = out_base_ff;
   assign rsp_ch.next_pc        = out_pc_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.last           = out_last_ff;

   `MMRS_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ch.ready)
   `MMRS_ASSERT_IMP(a_error_is_single, clock, reset,
      out_valid_ff && out_status_ff != mmrs_pkg::ST_OK, out_last_ff && !out_access_ff)
   `MMRS_ASSERT_NEXT(a_idle_after_last, clock, reset, emit && emit_last,
      state_ff == mmrs_pkg::SEQ_IDLE)
   `MMRS_ASSERT_IMP(a_no_emit_over_held, clock, reset, emit, slot_free)

endmodule

// ===== test/movem_tb_pkg.sv =====
// Scoreboard that predicts and checks the memory accesses of move-multiple instructions.
`timescale 1ns / 1ps

package movem_tb_pkg;

   typedef struct packed {
      logic        kind;
      logic [2:0]  ea_mode;
      logic [2:0]  reg_field;
      logic [15:0] reg_list;
      logic [31:0] base_address;
      logic [31:0] pc_in;
   } movem_instr_type;

   typedef struct packed {
      logic                 access_valid;
      logic                 is_store;
      logic [31:0]          access_address;
      logic [3:0]           reg_index;
      logic [31:0]          new_base;
      logic [31:0]          next_pc;
      mmrs_pkg::status_type status;
      logic                 last;
   } movem_access_type;

   class access_scoreboard;
      movem_access_type expected_accesses[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      // Expands one accepted instruction into the accesses it must produce.
      function void expand_instruction(movem_instr_type ins);
         movem_access_type acc;
         mmrs_pkg::status_type st;
         logic store;
         logic [31:0] addr;
         logic [31:0] pc_next;
         int pos;
         store = ~ins.kind;
         addr = ins.base_address;
         pc_next = ins.pc_in + mmrs_pkg::EXT_WORD_SIZE;
         unique case (ins.ea_mode)
            mmrs_pkg::MODE_PREDEC: st = store ? mmrs_pkg::ST_OK : mmrs_pkg::ST_ILLEGAL;
            mmrs_pkg::MODE_POSTINC: st = store ? mmrs_pkg::ST_ILLEGAL : mmrs_pkg::ST_OK;
            mmrs_pkg::MODE_ADDR_IND, mmrs_pkg::MODE_DISP, mmrs_pkg::MODE_INDEX:
               st = mmrs_pkg::ST_UNIMPL;
            mmrs_pkg::MODE_EXT:
               st = (ins.reg_field <= mmrs_pkg::EXT_LAST_UNIMPL)
                    ? mmrs_pkg::ST_UNIMPL : mmrs_pkg::ST_ILLEGAL;
            default: st = mmrs_pkg::ST_ILLEGAL;
         endcase
         acc = '0;
         acc.is_store = store;
         acc.status = st;
         acc.last = 1'b1;
         if (st != mmrs_pkg::ST_OK) begin
            expected_accesses.push_back(acc);
            return;
         end
         // An empty list still reports the base and pc, without an access.
         if (ins.reg_list == 16'd0) begin
            acc.new_base = addr;
            acc.next_pc = pc_next;
            expected_accesses.push_back(acc);
            return;
         end
         for (pos = 0; pos < 16; pos++) begin
            if (ins.reg_list[pos]) begin
               acc = '0;
               acc.access_valid = 1'b1;
               acc.is_store = store;
               acc.status = mmrs_pkg::ST_OK;
               // Stores walk the list backwards from A7, so bit 0 is A7.
               if (store) begin
                  addr = addr + mmrs_pkg::LONG_STEP_DOWN;
                  acc.access_address = addr;
                  acc.reg_index = 4'(15 - pos);
               end else begin
                  acc.access_address = addr;
                  addr = addr + mmrs_pkg::LONG_STEP_UP;
                  acc.reg_index = 4'(pos);
               end
               if ((ins.reg_list >> (pos + 1)) == 16'd0) begin
                  acc.last = 1'b1;
                  acc.new_base = addr;
                  acc.next_pc = pc_next;
               end
               expected_accesses.push_back(acc);
            end
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            failures++;
         end
      endfunction

      function void check_access(movem_access_type got);
         movem_access_type exp_acc;
         if (expected_accesses.size() == 0) begin
            $error("access transfer with nothing expected: address 0x%0h", got.access_address);
            failures++;
            return;
         end
         exp_acc = expected_accesses.pop_front();
         compare_field("access_valid", 32'(exp_acc.access_valid), 32'(got.access_valid));
         compare_field("is_store", 32'(exp_acc.is_store), 32'(got.is_store));
         compare_field("access_address", exp_acc.access_address, got.access_address);
         compare_field("reg_index", 32'(exp_acc.reg_index), 32'(got.reg_index));
         compare_field("new_base", exp_acc.new_base, got.new_base);
         compare_field("next_pc", exp_acc.next_pc, got.next_pc);
         compare_field("status", 32'(exp_acc.status), 32'(got.status));
         compare_field("last", 32'(exp_acc.last), 32'(got.last));
      endfunction
   endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench driving the move-multiple sequencer and checking its accesses.
`timescale 1ns / 1ps

module tb_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   int sent_count = 0;
   int quiet_cycles = 0;
   bit steady = 1'b0;
   movem_tb_pkg::access_scoreboard board = new();

   mmrs_req_if req_bus ();
   mmrs_rsp_if rsp_bus ();

   move_multiple_register_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #5 clock = ~clock;

   function automatic movem_tb_pkg::movem_instr_type make_instr(logic kind, logic [2:0] mode,
                                                                logic [2:0] field,
                                                                logic [15:0] mask,
                                                                logic [31:0] base,
                                                                logic [31:0] pc);
      movem_tb_pkg::movem_instr_type ins;
      ins.kind = kind;
      ins.ea_mode = mode;
      ins.reg_field = field;
      ins.reg_list = mask;
      ins.base_address = base;
      ins.pc_in = pc;
      return ins;
   endfunction

   // Offers one instruction and returns at the edge where the transfer happens.
   task automatic send_instruction(movem_tb_pkg::movem_instr_type ins);
      bit idled;
      idled = 1'b0;
      while (!steady && $urandom_range(99) < 31) begin
         if (!idled) begin
            req_bus.valid <= 1'b0;
            idled = 1'b1;
         end
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= ins.kind;
      req_bus.ea_mode <= ins.ea_mode;
      req_bus.reg_field <= ins.reg_field;
      req_bus.reg_list <= ins.reg_list;
      req_bus.base_address <= ins.base_address;
      req_bus.pc_in <= ins.pc_in;
      do @(posedge clock); while (!req_bus.ready);
      board.expand_instruction(ins);
      sent_count++;
   endtask

   // Result side: checks each transfer and stalls at random, once for a long stretch.
   initial begin
      movem_tb_pkg::movem_access_type got;
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.access_valid = rsp_bus.access_valid;
            got.is_store = rsp_bus.is_store;
            got.access_address = rsp_bus.access_address;
            got.reg_index = rsp_bus.reg_index;
            got.new_base = rsp_bus.new_base;
            got.next_pc = rsp_bus.next_pc;
            got.status = mmrs_pkg::status_type'(rsp_bus.status);
            got.last = rsp_bus.last;
            board.check_access(got);
         end
         if (!hold_done && sent_count >= 40) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no transfer for %0d cycles", QUIET_LIMIT);
         $display("move_multiple_register_sequencer regression: fail");
         $finish;
      end
   end

   initial begin
      movem_tb_pkg::movem_instr_type ins;
      int n;
      int pick;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.kind <= 1'b0;
      req_bus.ea_mode <= 3'd0;
      req_bus.reg_field <= 3'd0;
      req_bus.reg_list <= 16'd0;
      req_bus.base_address <= 32'd0;
      req_bus.pc_in <= 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Full lists with address and pc wrap in both directions.
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_PREDEC, 3'd7, 16'hFFFF,
                                  32'h0000_0008, 32'hFFFF_FFFE));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_POSTINC, 3'd0, 16'hFFFF,
                                  32'hFFFF_FFF8, 32'hFFFF_FFFF));
      // Empty lists.
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_PREDEC, 3'd2, 16'h0000,
                                  32'hFFFF_FFFF, 32'h0000_0000));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_POSTINC, 3'd5, 16'h0000,
                                  32'h0000_0000, 32'h1234_5678));
      // Single registers at both ends of the list, then alternating lists.
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_PREDEC, 3'd1, 16'h0001,
                                  32'h0000_1000, 32'h0000_0100));
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_PREDEC, 3'd6, 16'h8000,
                                  32'h0000_0000, 32'h0000_0200));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_POSTINC, 3'd3, 16'h0001,
                                  32'hFFFF_FFFC, 32'h0000_0300));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_POSTINC, 3'd4, 16'h8000,
                                  32'h8000_0000, 32'h0000_0400));
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_PREDEC, 3'd0, 16'hAAAA,
                                  32'hDEAD_BEEF, 32'h0000_0500));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_POSTINC, 3'd7, 16'h5555,
                                  32'h0000_0002, 32'h0000_0600));
      // Direction that does not match the mode.
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_POSTINC, 3'd2, 16'hFFFF,
                                  32'h0000_2000, 32'h0000_0700));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_PREDEC, 3'd5, 16'hFFFF,
                                  32'h0000_3000, 32'h0000_0800));
      // Modes without an implementation, illegal extended subcodes, and register modes.
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_ADDR_IND, 3'd1, 16'h00FF,
                                  32'h0000_4000, 32'h0000_0900));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_DISP, 3'd6, 16'hFF00,
                                  32'h0000_5000, 32'h0000_0A00));
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_INDEX, 3'd4, 16'h1234,
                                  32'h0000_6000, 32'h0000_0B00));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_EXT, 3'd0, 16'hFFFF,
                                  32'h0000_7000, 32'h0000_0C00));
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_EXT, mmrs_pkg::EXT_LAST_UNIMPL, 16'h0F0F,
                                  32'h0, 32'h0D00));
      send_instruction(make_instr(1'b1, mmrs_pkg::MODE_EXT, 3'd4, 16'hF0F0,
                                  32'h0000_8000, 32'h0000_0E00));
      send_instruction(make_instr(1'b0, mmrs_pkg::MODE_EXT, 3'd7, 16'hFFFF,
                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_instruction(make_instr(1'b0, 3'd0, 3'd3, 16'hFFFF, 32'h0000_9000, 32'h0000_0F00));
      send_instruction(make_instr(1'b1, 3'd1, 3'd2, 16'hFFFF, 32'h0000_A000, 32'h0000_1000));

      for (n = 0; n < 320; n++) begin
         steady = (n >= 150 && n < 200);
         ins.kind = 1'($urandom_range(1));
         ins.reg_field = 3'($urandom_range(7));
         // Most instructions use the supported mode for their direction.
         if ($urandom_range(99) < 80) begin
            ins.ea_mode = ins.kind ? mmrs_pkg::MODE_POSTINC : mmrs_pkg::MODE_PREDEC;
         end else begin
            ins.ea_mode = 3'($urandom_range(7));
         end
         pick = $urandom_range(9);
         unique case (pick)
            0: ins.reg_list = 16'h0000;
            1: ins.reg_list = 16'h0001 << $urandom_range(15);
            2: ins.reg_list = 16'hFFFF;
            default: ins.reg_list = 16'($urandom);
         endcase
         pick = $urandom_range(7);
         unique case (pick)
            0: ins.base_address = 32'($urandom_range(64));
            1: ins.base_address = 32'hFFFF_FFFF - 32'($urandom_range(64));
            default: ins.base_address = $urandom;
         endcase
         ins.pc_in = ($urandom_range(9) == 0) ? 32'hFFFF_FFFE + 32'($urandom_range(1)) : $urandom;
         send_instruction(ins);
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (board.expected_accesses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.expected_accesses.size() == 0) begin
         $display("move_multiple_register_sequencer regression: pass");
      end else begin
         $display("move_multiple_register_sequencer regression: fail");
      end
      $finish;
   end

endmodule
